@@ src/set_assoc_lru_cache_model_defines.svh @@
// Assertion macros shared by the cache model RTL.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define SALC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Expression must never be true outside reset.
`define SALC_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define SALC_ASSERT(lbl, clk, rst, prop)
`define SALC_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

@@ src/salc_pkg.sv @@
// Shared types and codes for the set-associative LRU cache model.
package salc_pkg;

   // Width of the running hit, miss and eviction totals
   localparam int COUNT_W = 32;

   // Request type codes
   localparam logic [1:0] REQ_MODIFY  = 2'd2;
   localparam logic [1:0] REQ_IGNORED = 2'd3;

   // Configuration register indexes
   localparam logic [1:0] CSR_SET_BITS   = 2'd0;
   localparam logic [1:0] CSR_BLOCK_BITS = 2'd1;
   localparam logic [1:0] CSR_WAYS       = 2'd2;

   // Access outcome
   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_FILL  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   // Control sequencer states
   typedef enum logic [1:0] {
      ST_CLEAR  = 2'd0,
      ST_IDLE   = 2'd1,
      ST_LOOKUP = 2'd2
   } state_type;

endpackage

@@ src/salc_row_mem.sv @@
// Single-port-write, registered-read memory holding one cache set per row.
module salc_row_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] rows_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rows_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= rows_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/salc_set_update.sv @@
// Tag match, victim choice and LRU rank update for one cache set.
module salc_set_update #(
   parameter int NUM_WAYS = 8,
   parameter int RANK_W   = 3,
   parameter int TAG_W    = 64
) (
   input  logic [4:0]                         ways_eff,
   input  logic [TAG_W-1:0]                   lookup_tag,
   input  logic [NUM_WAYS-1:0]                cur_valid,
   input  logic [NUM_WAYS-1:0][RANK_W-1:0]    cur_rank,
   input  logic [NUM_WAYS-1:0][TAG_W-1:0]     cur_tag,
   output logic [NUM_WAYS-1:0]                new_valid,
   output logic [NUM_WAYS-1:0][RANK_W-1:0]    new_rank,
   output logic [NUM_WAYS-1:0][TAG_W-1:0]     new_tag,
   output salc_pkg::outcome_type              outcome
);

   localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(NUM_WAYS - 1);

   logic [NUM_WAYS-1:0] in_use;
   logic [NUM_WAYS-1:0] match;
   logic [NUM_WAYS-1:0] free;
   logic [NUM_WAYS-1:0] is_oldest;
   logic [WAY_W-1:0]    hit_way;
   logic [WAY_W-1:0]    free_way;
   logic [WAY_W-1:0]    old_way;
   logic [WAY_W-1:0]    used_way;
   logic [RANK_W-1:0]   used_rank;
   logic                hit;
   logic                have_free;

   // per-way status, all ways compared in parallel
   always_comb begin
      for (int v = 0; v < NUM_WAYS; v++) begin
         in_use[v] = (5'(v) < ways_eff);
         match[v]  = in_use[v] && cur_valid[v] && (cur_tag[v] == lookup_tag);
         free[v]   = in_use[v] && !cur_valid[v];
      end
   end

   // a way is oldest when no way in use outranks it
   always_comb begin
      for (int v = 0; v < NUM_WAYS; v++) begin
         is_oldest[v] = in_use[v];
         for (int u = 0; u < NUM_WAYS; u++) begin
            if (in_use[u] && (cur_rank[u] > cur_rank[v])) begin
               is_oldest[v] = 1'b0;
            end
         end
      end
   end

   // lowest-numbered way wins in each group
   always_comb begin
      hit_way  = '0;
      free_way = '0;
      old_way  = '0;
      for (int v = NUM_WAYS - 1; v >= 0; v--) begin
         if (match[v]) begin
            hit_way = WAY_W'(v);
         end
         if (free[v]) begin
            free_way = WAY_W'(v);
         end
         if (is_oldest[v]) begin
            old_way = WAY_W'(v);
         end
      end
   end

   assign hit       = |match;
   assign have_free = |free;

   // choose the line this access uses and report how it got there
   always_comb begin
      priority if (hit) begin
         used_way = hit_way;
         outcome  = salc_pkg::OUT_HIT;
      end else if (have_free) begin
         used_way = free_way;
         outcome  = salc_pkg::OUT_FILL;
      end else begin
         used_way = old_way;
         outcome  = salc_pkg::OUT_EVICT;
      end
   end

   assign used_rank = cur_rank[used_way];

   // used line becomes most recent; younger lines (all of them on a miss) age
   always_comb begin
      for (int v = 0; v < NUM_WAYS; v++) begin
         new_valid[v] = cur_valid[v];
         new_rank[v]  = cur_rank[v];
         new_tag[v]   = cur_tag[v];
         if (WAY_W'(v) == used_way) begin
            new_valid[v] = 1'b1;
            new_rank[v]  = '0;
            new_tag[v]   = lookup_tag;
         end else if (in_use[v] && cur_valid[v] && (!hit || (cur_rank[v] < used_rank))
                      && (cur_rank[v] < RANK_MAX)) begin
            new_rank[v] = cur_rank[v] + RANK_W'(1);
         end
      end
   end

endmodule

@@ src/set_assoc_lru_cache_model.sv @@
// Set-associative LRU cache tag model: sequencer, set memory and running totals.
// The request and its set read are registered, then the result is registered once the output frees.
// A new request can be taken as the last access of the previous one completes; load and store make one
// access each, modify two, and the shared update logic does one access per cycle while the output is free.
// Reset clears the totals and sets the configuration to its defaults, then a clearing
// pass writes every set row to invalid while no request is taken.
`include "set_assoc_lru_cache_model_defines.svh"

module set_assoc_lru_cache_model #(
   parameter int NUM_SETS   = 64,
   parameter int NUM_WAYS   = 8,
   parameter int ADDR_WIDTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [5:0]  csr_wdata,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_address,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_outcome,
   output logic        rsp_last_of_request,
   output logic [salc_pkg::COUNT_W-1:0] rsp_hit_total,
   output logic [salc_pkg::COUNT_W-1:0] rsp_miss_total,
   output logic [salc_pkg::COUNT_W-1:0] rsp_eviction_total
);

   localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int RANK_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
   localparam int ROW_W  = NUM_WAYS * (1 + RANK_W + ADDR_WIDTH);
   localparam int SET_BITS_MAX = $clog2(NUM_SETS + 1) - 1;
   localparam logic [2:0] SET_CLAMP = 3'((SET_BITS_MAX > 7) ? 7 : SET_BITS_MAX);
   localparam logic [SET_W-1:0] LAST_SET = SET_W'(NUM_SETS - 1);
   localparam logic [salc_pkg::COUNT_W-1:0] COUNT_ONE = salc_pkg::COUNT_W'(1);

   // control state
   salc_pkg::state_type state_ff, state_in;
   logic [SET_W-1:0]    clr_idx_ff, clr_idx_in;
   logic                second_ff, second_in;
   logic                fwd_sel_ff, fwd_sel_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          set_bits_ff, set_bits_in;
   logic [5:0]          block_bits_ff, block_bits_in;
   logic [3:0]          ways_ff, ways_in;
   logic [salc_pkg::COUNT_W-1:0] hits_ff, hits_in;
   logic [salc_pkg::COUNT_W-1:0] misses_ff, misses_in;
   logic [salc_pkg::COUNT_W-1:0] evicts_ff, evicts_in;

   // payload state
   logic                  modify_ff, modify_in;
   logic [SET_W-1:0]      set_ff, set_in;
   logic [ADDR_WIDTH-1:0] tag_ff, tag_in;
   logic [ROW_W-1:0]      fwd_row_ff, fwd_row_in;
   salc_pkg::outcome_type outcome_ff, outcome_in;
   logic                  last_ff, last_in;

   // datapath
   logic [ADDR_WIDTH-1:0] addr_masked;
   logic [ADDR_WIDTH-1:0] addr_shifted;
   logic [2:0]            set_bits_eff;
   logic [6:0]            tag_shift;
   logic [SET_W-1:0]      set_mask;
   logic [SET_W-1:0]      req_set;
   logic [ADDR_WIDTH-1:0] req_tag;
   logic [4:0]            ways_eff;
   logic                  out_free;
   logic                  req_take;
   logic                  do_access;
   logic                  mem_wr_en;
   logic [SET_W-1:0]      mem_wr_addr;
   logic [ROW_W-1:0]      mem_wr_data;
   logic                  mem_rd_en;
   logic [ROW_W-1:0]      mem_rd_data;
   logic [ROW_W-1:0]      cur_row;
   logic [ROW_W-1:0]      new_row;
   logic [NUM_WAYS-1:0]                    cur_valid, new_valid;
   logic [NUM_WAYS-1:0][RANK_W-1:0]        cur_rank, new_rank;
   logic [NUM_WAYS-1:0][ADDR_WIDTH-1:0]    cur_tag, new_tag;
   salc_pkg::outcome_type                  acc_outcome;
   logic                  clearing;
   logic                  modify_wait;

   // configuration writes; unknown indexes are dropped
   always_comb begin
      set_bits_in   = set_bits_ff;
      block_bits_in = block_bits_ff;
      ways_in       = ways_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            salc_pkg::CSR_SET_BITS:   set_bits_in   = csr_wdata[2:0];
            salc_pkg::CSR_BLOCK_BITS: block_bits_in = csr_wdata;
            salc_pkg::CSR_WAYS:       ways_in       = csr_wdata[3:0];
            default:                  ;
         endcase
      end
   end

   // effective associativity: zero acts as one, clamp at NUM_WAYS
   always_comb begin
      priority if (ways_ff == 4'd0) begin
         ways_eff = 5'd1;
      end else if ({1'b0, ways_ff} > 5'(NUM_WAYS)) begin
         ways_eff = 5'(NUM_WAYS);
      end else begin
         ways_eff = {1'b0, ways_ff};
      end
   end

   // split the incoming address into set index and tag
   assign set_bits_eff = (set_bits_ff < SET_CLAMP) ? set_bits_ff : SET_CLAMP;
   assign addr_masked  = req_address[ADDR_WIDTH-1:0];
   assign addr_shifted = addr_masked >> block_bits_ff;
   assign tag_shift    = {4'd0, set_bits_eff} + {1'b0, block_bits_ff};
   assign req_tag      = addr_masked >> tag_shift;

   always_comb begin
      for (int i = 0; i < SET_W; i++) begin
         set_mask[i] = (3'(i) < set_bits_eff) && (i < 7);
      end
   end

   assign req_set = addr_shifted[SET_W-1:0] & set_mask;

   // row under work: forwarded copy when the set was just written
   assign cur_row = fwd_sel_ff ? fwd_row_ff : mem_rd_data;
   assign {cur_valid, cur_rank, cur_tag} = cur_row;
   assign new_row = {new_valid, new_rank, new_tag};

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer: next state, memory control and request stall
   always_comb begin
      state_in    = state_ff;
      clr_idx_in  = clr_idx_ff;
      second_in   = second_ff;
      modify_in   = modify_ff;
      set_in      = set_ff;
      tag_in      = tag_ff;
      fwd_sel_in  = fwd_sel_ff;
      fwd_row_in  = fwd_row_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = set_ff;
      mem_wr_data = new_row;
      mem_rd_en   = 1'b0;
      req_stall   = 1'b1;
      req_take    = 1'b0;
      do_access   = 1'b0;

      unique case (state_ff)
         salc_pkg::ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_idx_ff;
            mem_wr_data = '0;
            if (clr_idx_ff == LAST_SET) begin
               state_in = salc_pkg::ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + SET_W'(1);
            end
         end
         salc_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            req_take  = req_valid;
         end
         salc_pkg::ST_LOOKUP: begin
            if (out_free) begin
               do_access = 1'b1;
               mem_wr_en = 1'b1;
               if (modify_ff && !second_ff) begin
                  // second access of a modify works on the row just written
                  second_in  = 1'b1;
                  fwd_sel_in = 1'b1;
                  fwd_row_in = new_row;
               end else begin
                  state_in  = salc_pkg::ST_IDLE;
                  req_stall = 1'b0;
                  req_take  = req_valid;
               end
            end
         end
         default: begin
            state_in = salc_pkg::ST_IDLE;
         end
      endcase

      // new request transfer: start the set read or forward the fresh row
      if (req_take) begin
         if (req_type == salc_pkg::REQ_IGNORED) begin
            state_in = salc_pkg::ST_IDLE;
         end else begin
            state_in  = salc_pkg::ST_LOOKUP;
            modify_in = (req_type == salc_pkg::REQ_MODIFY);
            second_in = 1'b0;
            set_in    = req_set;
            tag_in    = req_tag;
            if ((state_ff == salc_pkg::ST_LOOKUP) && (req_set == set_ff)) begin
               fwd_sel_in = 1'b1;
               fwd_row_in = new_row;
            end else begin
               fwd_sel_in = 1'b0;
               mem_rd_en  = 1'b1;
            end
         end
      end
   end

   // result register and saturating totals
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      outcome_in   = outcome_ff;
      last_in      = last_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      if (do_access) begin
         rsp_valid_in = 1'b1;
         outcome_in   = acc_outcome;
         last_in      = !modify_ff || second_ff;
         if (acc_outcome == salc_pkg::OUT_HIT) begin
            hits_in = (hits_ff == '1) ? hits_ff : hits_ff + COUNT_ONE;
         end else begin
            misses_in = (misses_ff == '1) ? misses_ff : misses_ff + COUNT_ONE;
         end
         if (acc_outcome == salc_pkg::OUT_EVICT) begin
            evicts_in = (evicts_ff == '1) ? evicts_ff : evicts_ff + COUNT_ONE;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= salc_pkg::ST_CLEAR;
         clr_idx_ff    <= '0;
         second_ff     <= 1'b0;
         fwd_sel_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         set_bits_ff   <= 3'd0;
         block_bits_ff <= 6'd0;
         ways_ff       <= 4'd1;
         hits_ff       <= '0;
         misses_ff     <= '0;
         evicts_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         second_ff     <= second_in;
         fwd_sel_ff    <= fwd_sel_in;
         rsp_valid_ff  <= rsp_valid_in;
         set_bits_ff   <= set_bits_in;
         block_bits_ff <= block_bits_in;
         ways_ff       <= ways_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         evicts_ff     <= evicts_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      modify_ff  <= modify_in;
      set_ff     <= set_in;
      tag_ff     <= tag_in;
      fwd_row_ff <= fwd_row_in;
      outcome_ff <= outcome_in;
      last_ff    <= last_in;
   end

   salc_row_mem #(
      .DEPTH  (NUM_SETS),
      .ADDR_W (SET_W),
      .DATA_W (ROW_W)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (req_set),
      .rd_data (mem_rd_data)
   );

   salc_set_update #(
      .NUM_WAYS (NUM_WAYS),
      .RANK_W   (RANK_W),
      .TAG_W    (ADDR_WIDTH)
   ) u_set_update (
      .ways_eff   (ways_eff),
      .lookup_tag (tag_ff),
      .cur_valid  (cur_valid),
      .cur_rank   (cur_rank),
      .cur_tag    (cur_tag),
      .new_valid  (new_valid),
      .new_rank   (new_rank),
      .new_tag    (new_tag),
      .outcome    (acc_outcome)
   );

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_outcome         = outcome_ff;
   assign rsp_last_of_request = last_ff;
   assign rsp_hit_total       = hits_ff;
   assign rsp_miss_total      = misses_ff;
   assign rsp_eviction_total  = evicts_ff;

   // sequencer status seen by the checks below
   assign clearing    = (state_ff == salc_pkg::ST_CLEAR);
   assign modify_wait = (state_ff == salc_pkg::ST_LOOKUP) && second_ff && modify_ff;

   // no request may enter while the set memory is being cleared
   `SALC_ASSERT_NEVER(a_no_take_in_clear, clock, reset, clearing && req_valid && !req_stall)
   // every eviction is also a miss, saturation included
   `SALC_ASSERT(a_evict_le_miss, clock, reset, rsp_eviction_total <= rsp_miss_total)
   // hit total only grows between resets
   `SALC_ASSERT(a_hits_up, clock, reset, !$past(reset) |-> (rsp_hit_total >= $past(rsp_hit_total)))
   // first result of a modify is shown only while its second access is pending
   `SALC_ASSERT(a_modify_wait, clock, reset, (rsp_valid && !rsp_last_of_request) |-> modify_wait)

endmodule
